// ===== rtl/gcrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcrf_pkg - GPIO controller register file package
// Shared types, register offsets and codes for the GPIO register file.
// ----------------------------------------------------------------------------
package gcrf_pkg;

    // Default build sizes
    localparam int unsigned DEF_NUM_PINS  = 54;
    localparam int unsigned DEF_PULL_PINS = 32;

    // Function select layout
    localparam int unsigned PINS_PER_SELECT = 10;
    localparam int unsigned FSEL_FN_BITS    = 3;
    localparam int unsigned FSEL_BITS       = FSEL_FN_BITS * PINS_PER_SELECT;
    localparam int unsigned FSEL_WORDS      = 6;
    localparam int unsigned FSEL_IDX_BITS   = $clog2(FSEL_WORDS);

    // Pads block
    localparam int unsigned PAD_COUNT    = 3;
    localparam int unsigned PAD_IDX_BITS = $clog2(PAD_COUNT);
    localparam int unsigned PAD_BITS     = 5;
    localparam logic [7:0]  PAD_PASSWORD = 8'h5A;

    // Bus word
    localparam int unsigned DATA_BITS = 32;
    localparam int unsigned OFF_BITS  = 6;

    // Access codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam logic BLK_GPIO  = 1'b0;
    localparam logic BLK_PADS  = 1'b1;

    // Word offsets, gpio block
    localparam logic [OFF_BITS-1:0] OFF_FSEL_FIRST = 6'd0;
    localparam logic [OFF_BITS-1:0] OFF_FSEL_LAST  = 6'd5;
    localparam logic [OFF_BITS-1:0] OFF_SET_LO     = 6'd7;
    localparam logic [OFF_BITS-1:0] OFF_SET_HI     = 6'd8;
    localparam logic [OFF_BITS-1:0] OFF_CLR_LO     = 6'd10;
    localparam logic [OFF_BITS-1:0] OFF_CLR_HI     = 6'd11;
    localparam logic [OFF_BITS-1:0] OFF_LEV_LO     = 6'd13;
    localparam logic [OFF_BITS-1:0] OFF_LEV_HI     = 6'd14;
    localparam logic [OFF_BITS-1:0] OFF_PUD        = 6'd37;
    localparam logic [OFF_BITS-1:0] OFF_UDCLK      = 6'd38;

    // Word offsets, pads block
    localparam logic [OFF_BITS-1:0] OFF_PADS_FIRST = 6'd11;
    localparam logic [OFF_BITS-1:0] OFF_PADS_LAST  = 6'd13;

    // Pull codes
    localparam logic [1:0] PULL_NONE = 2'd0;
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    // Decoded access
    typedef struct packed {
        logic                     fsel_wr;
        logic                     fsel_rd;
        logic                     set_wr;
        logic                     clr_wr;
        logic                     lev_rd;
        logic                     pud_wr;
        logic                     pud_rd;
        logic                     udclk_wr;
        logic                     pads_wr;
        logic                     pads_rd;
        logic                     hi;
        logic [FSEL_IDX_BITS-1:0] fsel_idx;
        logic [PAD_IDX_BITS-1:0]  pad_idx;
        logic                     err;
    } t_dec;

    // Bits of one fsel word that map onto existing pins
    function automatic logic [FSEL_BITS-1:0] fsel_row_mask(input int unsigned row,
                                                           input int unsigned num_pins);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int unsigned j = 0; j < PINS_PER_SELECT; j++) begin
            if (row * PINS_PER_SELECT + j < num_pins) begin
                m[j*FSEL_FN_BITS +: FSEL_FN_BITS] = '1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gcrf_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcrf_decode - access decoder
// Turns command, block and word offset into register strobes and error.
// ----------------------------------------------------------------------------
module gcrf_decode (
    input  wire logic                          i_cmd,
    input  wire logic                          i_block_sel,
    input  wire logic [gcrf_pkg::OFF_BITS-1:0] i_word_offset,
    input  wire logic [7:0]                    i_pw_byte,
    output gcrf_pkg::t_dec                     o_dec
);

    logic                          w_wr;
    logic                          w_rd;
    logic                          w_pw_ok;
    logic [gcrf_pkg::OFF_BITS-1:0] w_pad_off;

    assign w_wr      = (i_cmd == gcrf_pkg::CMD_WRITE);
    assign w_rd      = (i_cmd == gcrf_pkg::CMD_READ);
    assign w_pw_ok   = (i_pw_byte == gcrf_pkg::PAD_PASSWORD);
    assign w_pad_off = i_word_offset - gcrf_pkg::OFF_PADS_FIRST;

    always_comb begin
        o_dec          = '0;
        o_dec.fsel_idx = i_word_offset[gcrf_pkg::FSEL_IDX_BITS-1:0];
        o_dec.pad_idx  = w_pad_off[gcrf_pkg::PAD_IDX_BITS-1:0];
        o_dec.hi       = (i_word_offset == gcrf_pkg::OFF_SET_HI) ||
                         (i_word_offset == gcrf_pkg::OFF_CLR_HI) ||
                         (i_word_offset == gcrf_pkg::OFF_LEV_HI);
        if (i_block_sel == gcrf_pkg::BLK_PADS) begin
            unique case (i_word_offset) inside
                [gcrf_pkg::OFF_PADS_FIRST:gcrf_pkg::OFF_PADS_LAST]: begin
                    o_dec.pads_rd = w_rd;
                    o_dec.pads_wr = w_wr && w_pw_ok;
                    o_dec.err     = w_wr && !w_pw_ok;
                end
                default: begin
                    o_dec.err = 1'b1;
                end
            endcase
        end else begin
            unique case (i_word_offset) inside
                [gcrf_pkg::OFF_FSEL_FIRST:gcrf_pkg::OFF_FSEL_LAST]: begin
                    o_dec.fsel_wr = w_wr;
                    o_dec.fsel_rd = w_rd;
                end
                gcrf_pkg::OFF_SET_LO, gcrf_pkg::OFF_SET_HI: begin
                    o_dec.set_wr = w_wr;
                end
                gcrf_pkg::OFF_CLR_LO, gcrf_pkg::OFF_CLR_HI: begin
                    o_dec.clr_wr = w_wr;
                end
                gcrf_pkg::OFF_LEV_LO, gcrf_pkg::OFF_LEV_HI: begin
                    // level words ignore writes without complaint
                    o_dec.lev_rd = w_rd;
                end
                gcrf_pkg::OFF_PUD: begin
                    o_dec.pud_wr = w_wr;
                    o_dec.pud_rd = w_rd;
                end
                gcrf_pkg::OFF_UDCLK: begin
                    o_dec.udclk_wr = w_wr;
                end
                default: begin
                    o_dec.err = 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gcrf_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcrf_regs - GPIO register state
// Function select, output latch, pull and pad registers with read mux.
// ----------------------------------------------------------------------------
module gcrf_regs #(
    parameter int unsigned NUM_PINS  = gcrf_pkg::DEF_NUM_PINS,
    parameter int unsigned PULL_PINS = gcrf_pkg::DEF_PULL_PINS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_adv,
    input  wire gcrf_pkg::t_dec                 i_dec,
    input  wire logic [gcrf_pkg::DATA_BITS-1:0] i_write_data,
    input  wire logic [NUM_PINS-1:0]            i_pin_inputs,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_read_data,
    output logic      [NUM_PINS-1:0]            o_next_latch,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_next_pull_up,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_next_pull_down
);

    localparam int unsigned DW = gcrf_pkg::DATA_BITS;
    localparam logic [DW-1:0] PullMask = DW'((64'd1 << PULL_PINS) - 64'd1);

    logic [gcrf_pkg::FSEL_BITS-1:0] r_fsel [gcrf_pkg::FSEL_WORDS];
    logic [NUM_PINS-1:0]            r_latch;
    logic [1:0]                     r_pull_code;
    logic [DW-1:0]                  r_pull_up;
    logic [DW-1:0]                  r_pull_down;
    logic [gcrf_pkg::PAD_BITS-1:0]  r_pads [gcrf_pkg::PAD_COUNT];

    logic [2*DW-1:0]     w_lev;
    logic [2*DW-1:0]     w_data_wide;
    logic [NUM_PINS-1:0] w_pin_mask;
    logic [DW-1:0]       w_pull_mask;

    // Function select words, unused pin bits held at zero
    for (genvar gv = 0; gv < gcrf_pkg::FSEL_WORDS; gv++) begin : g_fsel
        localparam logic [gcrf_pkg::FSEL_BITS-1:0] RowMask =
            gcrf_pkg::fsel_row_mask(gv, NUM_PINS);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fsel[gv] <= '0;
            end else if (i_adv && i_dec.fsel_wr &&
                         i_dec.fsel_idx == gcrf_pkg::FSEL_IDX_BITS'(gv)) begin
                r_fsel[gv] <= i_write_data[gcrf_pkg::FSEL_BITS-1:0] & RowMask;
            end
        end
    end

    assign w_lev       = (2*DW)'(i_pin_inputs);
    assign w_data_wide = i_dec.hi ? {i_write_data, {DW{1'b0}}} : {{DW{1'b0}}, i_write_data};
    assign w_pin_mask  = w_data_wide[NUM_PINS-1:0];
    assign w_pull_mask = i_write_data & PullMask;

    // Output latch, write-one set and clear
    always_comb begin
        o_next_latch = r_latch;
        if (i_dec.set_wr) begin
            o_next_latch = r_latch | w_pin_mask;
        end else if (i_dec.clr_wr) begin
            o_next_latch = r_latch & ~w_pin_mask;
        end
    end

    // Pull clock: copy pull code into masked pins
    always_comb begin
        o_next_pull_up   = r_pull_up;
        o_next_pull_down = r_pull_down;
        if (i_dec.udclk_wr) begin
            case (r_pull_code)
                gcrf_pkg::PULL_UP: begin
                    o_next_pull_up   = r_pull_up | w_pull_mask;
                    o_next_pull_down = r_pull_down & ~w_pull_mask;
                end
                gcrf_pkg::PULL_DOWN: begin
                    o_next_pull_down = r_pull_down | w_pull_mask;
                    o_next_pull_up   = r_pull_up & ~w_pull_mask;
                end
                default: begin
                    o_next_pull_up   = r_pull_up & ~w_pull_mask;
                    o_next_pull_down = r_pull_down & ~w_pull_mask;
                end
            endcase
        end
    end

    // Read mux; strobes are already clear on writes and errors
    always_comb begin
        o_read_data = '0;
        if (i_dec.fsel_rd) begin
            o_read_data = DW'(r_fsel[i_dec.fsel_idx]);
        end else if (i_dec.lev_rd) begin
            o_read_data = i_dec.hi ? w_lev[2*DW-1:DW] : w_lev[DW-1:0];
        end else if (i_dec.pud_rd) begin
            o_read_data = DW'(r_pull_code);
        end else if (i_dec.pads_rd) begin
            o_read_data = DW'(r_pads[i_dec.pad_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch     <= '0;
            r_pull_code <= gcrf_pkg::PULL_NONE;
            r_pull_up   <= '0;
            r_pull_down <= '0;
            for (int i = 0; i < gcrf_pkg::PAD_COUNT; i++) begin
                r_pads[i] <= '0;
            end
        end else if (i_adv) begin
            r_latch     <= o_next_latch;
            r_pull_up   <= o_next_pull_up;
            r_pull_down <= o_next_pull_down;
            if (i_dec.pud_wr) begin
                r_pull_code <= i_write_data[1:0];
            end
            if (i_dec.pads_wr) begin
                r_pads[i_dec.pad_idx] <= i_write_data[gcrf_pkg::PAD_BITS-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gpio_controller_register_file_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_controller_register_file_unit - GPIO controller register file
// One register bus access per word: function select, set/clear latch,
// level read, pull control and password-guarded pad settings.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       i_in_valid/o_in_stall   cmd, block_sel, word_offset, write_data,
//                                   pin_inputs
//  out      o_out_valid/i_out_stall read_data, pin_outputs, pull_up_mask,
//                                   pull_down_mask, access_error
//
//  One word per cycle sustained while the output is not stalled; a word passes
//  through the input register, then decode and update into the result register.
//  Register state changes as a word moves into the result register.
//  Reset clears all register file state and both valid flags.
//  A stall on the output holds the result and backs up into the input
//  register; the input stalls only when that register cannot drain.
// ----------------------------------------------------------------------------
module gpio_controller_register_file_unit #(
    parameter int unsigned NUM_PINS  = gcrf_pkg::DEF_NUM_PINS,
    parameter int unsigned PULL_PINS = gcrf_pkg::DEF_PULL_PINS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_cmd,
    input  wire logic                           i_block_sel,
    input  wire logic [gcrf_pkg::OFF_BITS-1:0]  i_word_offset,
    input  wire logic [gcrf_pkg::DATA_BITS-1:0] i_write_data,
    input  wire logic [NUM_PINS-1:0]            i_pin_inputs,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_read_data,
    output logic      [NUM_PINS-1:0]            o_pin_outputs,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_pull_up_mask,
    output logic      [gcrf_pkg::DATA_BITS-1:0] o_pull_down_mask,
    output logic                                o_access_error
);

    localparam int unsigned DW = gcrf_pkg::DATA_BITS;

    logic                          r_in_valid;
    logic                          r_cmd;
    logic                          r_block_sel;
    logic [gcrf_pkg::OFF_BITS-1:0] r_word_offset;
    logic [DW-1:0]                 r_write_data;
    logic [NUM_PINS-1:0]           r_pin_inputs;

    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_accept;
    gcrf_pkg::t_dec                w_dec;
    logic [DW-1:0]                 w_read_data;
    logic [NUM_PINS-1:0]           w_next_latch;
    logic [DW-1:0]                 w_next_pull_up;
    logic [DW-1:0]                 w_next_pull_down;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd         <= i_cmd;
            r_block_sel   <= i_block_sel;
            r_word_offset <= i_word_offset;
            r_write_data  <= i_write_data;
            r_pin_inputs  <= i_pin_inputs;
        end
    end

    gcrf_decode u_decode (
        .i_cmd         (r_cmd),
        .i_block_sel   (r_block_sel),
        .i_word_offset (r_word_offset),
        .i_pw_byte     (r_write_data[DW-1:DW-8]),
        .o_dec         (w_dec)
    );

    gcrf_regs #(
        .NUM_PINS  (NUM_PINS),
        .PULL_PINS (PULL_PINS)
    ) u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_dec            (w_dec),
        .i_write_data     (r_write_data),
        .i_pin_inputs     (r_pin_inputs),
        .o_read_data      (w_read_data),
        .o_next_latch     (w_next_latch),
        .o_next_pull_up   (w_next_pull_up),
        .o_next_pull_down (w_next_pull_down)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_read_data      <= w_read_data;
            o_pin_outputs    <= w_next_latch;
            o_pull_up_mask   <= w_next_pull_up;
            o_pull_down_mask <= w_next_pull_down;
            o_access_error   <= w_dec.err;
        end
    end

endmodule
`default_nettype wire

// ===== tb/gpio_controller_register_file_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpio_controller_register_file_unit_tb - GPIO register file testbench
// Feeds directed and random register accesses through the input channel,
// predicts each result word from a local model of the register file and
// checks every field of the output word in order, under random idling,
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module gpio_controller_register_file_unit_tb;

    localparam int unsigned NUM_PINS    = gcrf_pkg::DEF_NUM_PINS;
    localparam int unsigned PULL_PINS   = gcrf_pkg::DEF_PULL_PINS;
    localparam int unsigned OB          = gcrf_pkg::OFF_BITS;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          N_RANDOM    = 650;
    localparam int          CALM_TAIL   = 120;

    typedef struct packed {
        logic                cmd;
        logic                blk;
        logic [OB-1:0]       off;
        logic [31:0]         wdata;
        logic [NUM_PINS-1:0] lev;
    } t_gpio_access;

    typedef struct packed {
        logic [31:0]         rdata;
        logic [NUM_PINS-1:0] pins;
        logic [31:0]         pu;
        logic [31:0]         pd;
        logic                err;
    } t_gpio_result;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 i_cmd            = gcrf_pkg::CMD_READ;
    logic                 i_block_sel      = gcrf_pkg::BLK_GPIO;
    logic [OB-1:0]        i_word_offset    = '0;
    logic [31:0]          i_write_data     = '0;
    logic [NUM_PINS-1:0]  i_pin_inputs     = '0;
    logic                 i_out_stall      = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [31:0]          o_read_data;
    logic [NUM_PINS-1:0]  o_pin_outputs;
    logic [31:0]          o_pull_up_mask;
    logic [31:0]          o_pull_down_mask;
    logic                 o_access_error;

    gpio_controller_register_file_unit #(
        .NUM_PINS  (NUM_PINS),
        .PULL_PINS (PULL_PINS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_block_sel      (i_block_sel),
        .i_word_offset    (i_word_offset),
        .i_write_data     (i_write_data),
        .i_pin_inputs     (i_pin_inputs),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_pin_outputs    (o_pin_outputs),
        .o_pull_up_mask   (o_pull_up_mask),
        .o_pull_down_mask (o_pull_down_mask),
        .o_access_error   (o_access_error)
    );

    always #1 i_clk = ~i_clk;

    // Model state of the register file
    logic [gcrf_pkg::FSEL_FN_BITS-1:0] pin_fn [NUM_PINS];
    logic [NUM_PINS-1:0]               latch;
    logic [1:0]                        pull_code;
    logic [31:0]                       pull_up_pins;
    logic [31:0]                       pull_down_pins;
    logic [gcrf_pkg::PAD_BITS-1:0]     pad_cfg [gcrf_pkg::PAD_COUNT];

    t_gpio_access pending_accesses [$];
    t_gpio_result due_results [$];
    t_gpio_access cur_access;

    int n_items    = 0;
    int n_accepted = 0;
    int n_fail     = 0;
    int n_cycles   = 0;
    int in_gap     = 0;
    int out_burst  = 0;
    int long_hold  = 0;
    bit hold_done  = 1'b0;

    function automatic t_gpio_result apply_access(input t_gpio_access a);
        t_gpio_result r;
        logic [63:0]  wide;
        logic [31:0]  mask;
        int unsigned  pin;
        logic         wr;
        r  = '0;
        wr = (a.cmd == gcrf_pkg::CMD_WRITE);
        if (a.blk == gcrf_pkg::BLK_PADS) begin
            if (a.off >= gcrf_pkg::OFF_PADS_FIRST && a.off <= gcrf_pkg::OFF_PADS_LAST) begin
                if (wr) begin
                    if (a.wdata[31:24] == gcrf_pkg::PAD_PASSWORD) begin
                        pad_cfg[a.off - gcrf_pkg::OFF_PADS_FIRST] =
                            a.wdata[gcrf_pkg::PAD_BITS-1:0];
                    end else begin
                        r.err = 1'b1;
                    end
                end else begin
                    r.rdata = 32'(pad_cfg[a.off - gcrf_pkg::OFF_PADS_FIRST]);
                end
            end else begin
                r.err = 1'b1;
            end
        end else if (a.off <= gcrf_pkg::OFF_FSEL_LAST) begin
            for (int unsigned j = 0; j < gcrf_pkg::PINS_PER_SELECT; j++) begin
                pin = a.off * gcrf_pkg::PINS_PER_SELECT + j;
                if (pin < NUM_PINS) begin
                    if (wr) begin
                        pin_fn[pin] =
                            a.wdata[j*gcrf_pkg::FSEL_FN_BITS +: gcrf_pkg::FSEL_FN_BITS];
                    end else begin
                        r.rdata[j*gcrf_pkg::FSEL_FN_BITS +: gcrf_pkg::FSEL_FN_BITS] =
                            pin_fn[pin];
                    end
                end
            end
        end else if (a.off == gcrf_pkg::OFF_SET_LO || a.off == gcrf_pkg::OFF_SET_HI) begin
            wide = {32'd0, a.wdata} << ((a.off == gcrf_pkg::OFF_SET_HI) ? 32 : 0);
            if (wr) latch = latch | wide[NUM_PINS-1:0];
        end else if (a.off == gcrf_pkg::OFF_CLR_LO || a.off == gcrf_pkg::OFF_CLR_HI) begin
            wide = {32'd0, a.wdata} << ((a.off == gcrf_pkg::OFF_CLR_HI) ? 32 : 0);
            if (wr) latch = latch & ~wide[NUM_PINS-1:0];
        end else if (a.off == gcrf_pkg::OFF_LEV_LO || a.off == gcrf_pkg::OFF_LEV_HI) begin
            wide = 64'(a.lev);
            if (!wr) begin
                r.rdata = (a.off == gcrf_pkg::OFF_LEV_HI) ? wide[63:32] : wide[31:0];
            end
        end else if (a.off == gcrf_pkg::OFF_PUD) begin
            if (wr) pull_code = a.wdata[1:0];
            else r.rdata = 32'(pull_code);
        end else if (a.off == gcrf_pkg::OFF_UDCLK) begin
            if (wr) begin
                mask = a.wdata & (32'hFFFF_FFFF >> (32 - PULL_PINS));
                case (pull_code)
                    gcrf_pkg::PULL_UP: begin
                        pull_up_pins   = pull_up_pins | mask;
                        pull_down_pins = pull_down_pins & ~mask;
                    end
                    gcrf_pkg::PULL_DOWN: begin
                        pull_down_pins = pull_down_pins | mask;
                        pull_up_pins   = pull_up_pins & ~mask;
                    end
                    default: begin
                        pull_up_pins   = pull_up_pins & ~mask;
                        pull_down_pins = pull_down_pins & ~mask;
                    end
                endcase
            end
        end else begin
            r.err = 1'b1;
        end
        if (wr || r.err) r.rdata = '0;
        r.pins = latch;
        r.pu   = pull_up_pins;
        r.pd   = pull_down_pins;
        return r;
    endfunction

    function automatic t_gpio_access mk_access(input logic cmd, input logic blk,
                                               input logic [OB-1:0] off,
                                               input logic [31:0] wdata,
                                               input logic [NUM_PINS-1:0] lev);
        t_gpio_access a;
        a.cmd   = cmd;
        a.blk   = blk;
        a.off   = off;
        a.wdata = wdata;
        a.lev   = lev;
        return a;
    endfunction

    function automatic logic [NUM_PINS-1:0] rand_levels();
        logic [63:0] r64;
        r64 = {$urandom(), $urandom()};
        return r64[NUM_PINS-1:0];
    endfunction

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_gpio_access rand_access();
        logic          cmd;
        logic [OB-1:0] off;
        logic [31:0]   wdata;
        int            pick;
        cmd   = $urandom_range(0, 1) ? gcrf_pkg::CMD_WRITE : gcrf_pkg::CMD_READ;
        wdata = rand_data();
        pick  = $urandom_range(0, 99);
        if (pick < 72) begin
            case ($urandom_range(0, 6))
                0, 1: off = gcrf_pkg::OFF_FSEL_FIRST +
                            OB'($urandom_range(0, gcrf_pkg::FSEL_WORDS - 1));
                2:    off = $urandom_range(0, 1) ? gcrf_pkg::OFF_SET_HI : gcrf_pkg::OFF_SET_LO;
                3:    off = $urandom_range(0, 1) ? gcrf_pkg::OFF_CLR_HI : gcrf_pkg::OFF_CLR_LO;
                4:    off = $urandom_range(0, 1) ? gcrf_pkg::OFF_LEV_HI : gcrf_pkg::OFF_LEV_LO;
                5:    off = gcrf_pkg::OFF_PUD;
                default: begin
                    off = gcrf_pkg::OFF_UDCLK;
                    cmd = $urandom_range(0, 3) ? gcrf_pkg::CMD_WRITE : gcrf_pkg::CMD_READ;
                end
            endcase
            return mk_access(cmd, gcrf_pkg::BLK_GPIO, off, wdata, rand_levels());
        end else if (pick < 88) begin
            off = gcrf_pkg::OFF_PADS_FIRST + OB'($urandom_range(0, gcrf_pkg::PAD_COUNT - 1));
            // mostly keep the password so that pad words really change
            if ($urandom_range(0, 3) != 0) wdata[31:24] = gcrf_pkg::PAD_PASSWORD;
            return mk_access(cmd, gcrf_pkg::BLK_PADS, off, wdata, rand_levels());
        end
        return mk_access(cmd, $urandom_range(0, 1) ? gcrf_pkg::BLK_PADS : gcrf_pkg::BLK_GPIO,
                         OB'($urandom_range(0, 63)), wdata, rand_levels());
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Input driver: offer queued words, hold while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) begin
                due_results.push_back(apply_access(cur_access));
                n_accepted++;
            end
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                cur_access = pending_accesses.pop_front();
                i_cmd         <= cur_access.cmd;
                i_block_sel   <= cur_access.blk;
                i_word_offset <= cur_access.off;
                i_write_data  <= cur_access.wdata;
                i_pin_inputs  <= cur_access.lev;
                i_in_valid    <= 1'b1;
                if (n_accepted < n_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 14);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random bursts plus one long hold-off to back up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= 250) begin
            hold_done = 1'b1;
            long_hold = 60;
            i_out_stall <= 1'b1;
        end else if (out_burst > 0) begin
            out_burst--;
            i_out_stall <= 1'b1;
        end else if (n_accepted < n_items - CALM_TAIL && $urandom_range(0, 7) == 0) begin
            out_burst = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_gpio_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_read_data);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                check_field("read_data", 64'(want.rdata), 64'(o_read_data));
                check_field("pin_outputs", 64'(want.pins), 64'(o_pin_outputs));
                check_field("pull_up_mask", 64'(want.pu), 64'(o_pull_up_mask));
                check_field("pull_down_mask", 64'(want.pd), 64'(o_pull_down_mask));
                check_field("access_error", 64'(want.err), 64'(o_access_error));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [NUM_PINS-1:0] ones;
        ones = '1;
        foreach (pin_fn[k]) pin_fn[k] = '0;
        foreach (pad_cfg[k]) pad_cfg[k] = '0;
        latch          = '0;
        pull_code      = gcrf_pkg::PULL_NONE;
        pull_up_pins   = '0;
        pull_down_pins = '0;

        // directed: extremes, every register type and the odd corners
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_FSEL_FIRST, '0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_FSEL_FIRST, '1, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_FSEL_FIRST, '0, ones));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_FSEL_LAST, '1, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_FSEL_LAST, '0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_SET_LO, '1, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_SET_HI, '1, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_SET_LO, '0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_CLR_HI, 32'hAAAA_AAAA, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_CLR_LO, 32'h5555_5555, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_LEV_LO, '0, ones));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_LEV_HI, '0, ones));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_LEV_LO, '1, ones));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_PUD, 32'hFFFF_FFFE, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_PUD, '0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_UDCLK, '1, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_PUD, 32'(gcrf_pkg::PULL_DOWN), '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_UDCLK, 32'h0000_FFFF, '0));
        // reserved pull code behaves as none
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_PUD, 32'd3, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_GPIO,
                                             gcrf_pkg::OFF_UDCLK, 32'h8000_00F0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_PADS,
                                             gcrf_pkg::OFF_PADS_FIRST, 32'h5A00_001F, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_PADS,
                                             gcrf_pkg::OFF_PADS_LAST, 32'hA5FF_FFFF, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_PADS,
                                             gcrf_pkg::OFF_PADS_FIRST, '0, '0));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_READ, gcrf_pkg::BLK_GPIO,
                                             6'd6, '1, ones));
        pending_accesses.push_back(mk_access(gcrf_pkg::CMD_WRITE, gcrf_pkg::BLK_PADS,
                                             6'd63, 32'h5A00_0011, '0));

        repeat (N_RANDOM) pending_accesses.push_back(rand_access());
        n_items = pending_accesses.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gcrf_pkg.sv
rtl/gcrf_decode.sv
rtl/gcrf_regs.sv
rtl/gpio_controller_register_file_unit.sv
tb/gpio_controller_register_file_unit_tb.sv
